// ----- hw/rtl/msched_pkg.sv -----
`default_nettype none
// msched_pkg: shared types and constants of the multicore scheduler
// no dependencies; imported by msched_ctrl, msched_dp and the top level

package msched_pkg;

    localparam int ID_W       = 8;
    localparam int QCNT_W     = 16;
    localparam int CORE_IDX_W = 3;
    localparam int MASK_W     = 8;

    localparam logic [QCNT_W-1:0] QCNT_MAX = {QCNT_W{1'b1}};

    // request command codes
    localparam logic CMD_ADMIT = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    // scheduling policy codes
    localparam logic POLICY_FCFS = 1'b0;
    localparam logic POLICY_RR   = 1'b1;

    // register index, taken from paddr[2]
    localparam logic REG_POLICY = 1'b0;
    localparam logic REG_QLIMIT = 1'b1;

    localparam logic [QCNT_W-1:0] QLIMIT_RESET = 16'd5;

    // controller to datapath
    typedef struct packed {
        logic load_item;
        logic do_admit;
        logic do_eval;
        logic do_push;
        logic do_read;
        logic do_pop;
        logic next_core;
    } msched_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic item_done;
    } msched_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/msched_ctrl.sv -----
`default_nettype none
// msched_ctrl: sequencing state machine of the scheduler
// depends on msched_pkg

module msched_ctrl
    import msched_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         req_valid,
    output logic              req_ready,
    input  wire logic         command,
    output logic              rsp_valid,
    input  wire logic         rsp_ready,
    input  wire msched_stat_t stat,
    output msched_cmd_t       cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ADMIT = 3'd1;
    localparam logic [2:0] S_EVAL  = 3'd2;
    localparam logic [2:0] S_PUSH  = 3'd3;
    localparam logic [2:0] S_READ  = 3'd4;
    localparam logic [2:0] S_POP   = 3'd5;
    localparam logic [2:0] S_WAIT  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = (command == CMD_ADMIT) ? S_ADMIT : S_EVAL;
                end
            end
            S_ADMIT:
            begin
                cmd.do_admit = 1'b1;
                state_next   = S_WAIT;
            end
            S_EVAL:
            begin
                cmd.do_eval = 1'b1;
                state_next  = S_PUSH;
            end
            S_PUSH:
            begin
                cmd.do_push = 1'b1;
                state_next  = S_READ;
            end
            S_READ:
            begin
                cmd.do_read = 1'b1;
                state_next  = S_POP;
            end
            S_POP:
            begin
                cmd.do_pop = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (rsp_ready)
                begin
                    if (stat.item_done)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.next_core = 1'b1;
                        state_next    = S_EVAL;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = (state_reg == S_WAIT);

endmodule

`default_nettype wire

// ----- hw/rtl/msched_dp.sv -----
`default_nettype none
// msched_dp: ready queue memory, per core state and result register
// depends on msched_pkg; driven by msched_ctrl commands

module msched_dp
    import msched_pkg::*;
#(
    parameter int NUM_CORES   = 4,
    parameter int QUEUE_DEPTH = 16
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire msched_cmd_t           cmd,
    output msched_stat_t               stat,
    input  wire logic                  policy,
    input  wire logic [QCNT_W-1:0]     quantum_limit,
    input  wire logic [ID_W-1:0]       process_id,
    input  wire logic [MASK_W-1:0]     finished_mask,
    output logic [CORE_IDX_W-1:0]      core_index,
    output logic                       retired_valid,
    output logic [ID_W-1:0]            retired_id,
    output logic                       preempted_valid,
    output logic [ID_W-1:0]            preempted_id,
    output logic                       dispatched_valid,
    output logic [ID_W-1:0]            dispatched_id,
    output logic                       queue_full,
    output logic                       last
);

    localparam int CW    = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
    localparam int QW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = QW + 1;

    localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(QUEUE_DEPTH);
    localparam logic [QW-1:0]    HEAD_LAST = QW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0]    CORE_LAST = CW'(NUM_CORES - 1);

    // ready queue storage
    logic [ID_W-1:0] mem [QUEUE_DEPTH];
    logic [ID_W-1:0] rd_data_reg;

    logic [QW-1:0]    head_reg;
    logic [CNT_W-1:0] count_reg;

    // per core state
    logic [NUM_CORES-1:0] busy_reg;
    logic [ID_W-1:0]      proc_reg [NUM_CORES];
    logic [QCNT_W-1:0]    qcnt_reg [NUM_CORES];

    // current item
    logic [ID_W-1:0]      pid_reg;
    logic [NUM_CORES-1:0] mask_reg;
    logic [CW-1:0]        core_reg;

    // per core step flags
    logic            ret_reg;
    logic [ID_W-1:0] ret_id_reg;
    logic            pre_reg;
    logic [ID_W-1:0] pre_id_reg;
    logic            pre_full_reg;
    logic            dis_reg;

    // result register
    logic [CORE_IDX_W-1:0] out_core_reg;
    logic                  out_ret_reg;
    logic [ID_W-1:0]       out_ret_id_reg;
    logic                  out_pre_reg;
    logic [ID_W-1:0]       out_pre_id_reg;
    logic                  out_dis_reg;
    logic [ID_W-1:0]       out_dis_id_reg;
    logic                  out_full_reg;
    logic                  out_last_reg;

    logic              busy_cur;
    logic              fin_cur;
    logic [QCNT_W-1:0] cnt_cur;
    logic [ID_W-1:0]   proc_cur;
    logic              ret_now;
    logic              pre_now;
    logic              inc_now;
    logic              full;
    logic              empty;
    logic [QW:0]       tail_sum;
    logic [QW:0]       tail_wrap;
    logic [QW-1:0]     tail;
    logic [QW-1:0]     head_inc;
    logic              mem_we;
    logic [QW-1:0]     mem_waddr;
    logic [ID_W-1:0]   mem_wdata;
    logic              cnt_up;
    logic              cnt_dn;

    assign busy_cur = busy_reg[core_reg];
    assign fin_cur  = mask_reg[core_reg];
    assign cnt_cur  = qcnt_reg[core_reg];
    assign proc_cur = proc_reg[core_reg];

    assign ret_now = busy_cur & fin_cur;
    assign pre_now = busy_cur & ~fin_cur & (policy == POLICY_RR) & (cnt_cur >= quantum_limit);
    assign inc_now = busy_cur & ~fin_cur & ~pre_now & (cnt_cur != QCNT_MAX);

    assign full  = (count_reg == CNT_FULL);
    assign empty = (count_reg == '0);

    // tail = (head + count) mod depth, the sum stays below twice the depth
    assign tail_sum  = {1'b0, head_reg} + count_reg;
    assign tail_wrap = (tail_sum >= CNT_FULL) ? (tail_sum - CNT_FULL) : tail_sum;
    assign tail      = tail_wrap[QW-1:0];
    assign head_inc  = (head_reg == HEAD_LAST) ? '0 : (head_reg + 1'b1);

    // preemption into a full queue refills the slot the head just left
    assign mem_we    = (cmd.do_admit & ~full)
                     | (cmd.do_push & pre_reg & ~pre_full_reg)
                     | (cmd.do_pop & dis_reg & pre_full_reg);
    assign mem_waddr = cmd.do_pop ? head_reg : tail;
    assign mem_wdata = cmd.do_admit ? pid_reg : pre_id_reg;

    assign cnt_up = (cmd.do_admit & ~full) | (cmd.do_push & pre_reg & ~pre_full_reg);
    assign cnt_dn = cmd.do_pop & dis_reg & ~pre_full_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.do_read)
        begin
            rd_data_reg <= mem[head_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= '0;
            count_reg    <= '0;
            core_reg     <= '0;
            busy_reg     <= '0;
            ret_reg      <= 1'b0;
            pre_reg      <= 1'b0;
            pre_full_reg <= 1'b0;
            dis_reg      <= 1'b0;
            out_ret_reg  <= 1'b0;
            out_pre_reg  <= 1'b0;
            out_dis_reg  <= 1'b0;
            out_full_reg <= 1'b0;
            out_last_reg <= 1'b0;
            for (int i = 0; i < NUM_CORES; i++)
            begin
                qcnt_reg[i] <= '0;
            end
        end
        else
        begin
            if (cnt_up)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (cnt_dn)
            begin
                count_reg <= count_reg - 1'b1;
            end

            if (cmd.load_item)
            begin
                core_reg <= '0;
            end
            else if (cmd.next_core)
            begin
                core_reg <= core_reg + 1'b1;
            end

            if (cmd.do_eval)
            begin
                ret_reg      <= ret_now;
                pre_reg      <= pre_now;
                pre_full_reg <= pre_now & full;
                if (ret_now || pre_now)
                begin
                    busy_reg[core_reg] <= 1'b0;
                    qcnt_reg[core_reg] <= '0;
                end
                else if (inc_now)
                begin
                    qcnt_reg[core_reg] <= cnt_cur + 1'b1;
                end
            end

            // dispatch is decided after retire, preempt and push have settled
            if (cmd.do_read)
            begin
                dis_reg <= pre_full_reg | (~busy_cur & ~empty);
            end

            if (cmd.do_pop)
            begin
                if (dis_reg)
                begin
                    head_reg           <= head_inc;
                    busy_reg[core_reg] <= 1'b1;
                    qcnt_reg[core_reg] <= '0;
                end
                out_ret_reg  <= ret_reg;
                out_pre_reg  <= pre_reg;
                out_dis_reg  <= dis_reg;
                out_full_reg <= 1'b0;
                out_last_reg <= (core_reg == CORE_LAST);
            end
            else if (cmd.do_admit)
            begin
                out_ret_reg  <= 1'b0;
                out_pre_reg  <= 1'b0;
                out_dis_reg  <= 1'b0;
                out_full_reg <= full;
                out_last_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            pid_reg  <= process_id;
            mask_reg <= finished_mask[NUM_CORES-1:0];
        end
        if (cmd.do_eval)
        begin
            ret_id_reg <= ret_now ? proc_cur : '0;
            pre_id_reg <= pre_now ? proc_cur : '0;
        end
        if (cmd.do_pop && dis_reg)
        begin
            proc_reg[core_reg] <= rd_data_reg;
        end
        if (cmd.do_pop)
        begin
            out_core_reg   <= CORE_IDX_W'(core_reg);
            out_ret_id_reg <= ret_id_reg;
            out_pre_id_reg <= pre_id_reg;
            out_dis_id_reg <= dis_reg ? rd_data_reg : '0;
        end
        else if (cmd.do_admit)
        begin
            out_core_reg   <= '0;
            out_ret_id_reg <= '0;
            out_pre_id_reg <= '0;
            out_dis_id_reg <= '0;
        end
    end

    assign core_index       = out_core_reg;
    assign retired_valid    = out_ret_reg;
    assign retired_id       = out_ret_id_reg;
    assign preempted_valid  = out_pre_reg;
    assign preempted_id     = out_pre_id_reg;
    assign dispatched_valid = out_dis_reg;
    assign dispatched_id    = out_dis_id_reg;
    assign queue_full       = out_full_reg;
    assign last             = out_last_reg;

    assign stat.item_done = out_last_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("ready queue count beyond depth");

    a_pre_full_implies_pre: assert property (@(posedge clk) disable iff (!rst_n)
        pre_full_reg |-> pre_reg)
        else $error("full queue preemption flag without preemption");

    a_ret_pre_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(out_ret_reg && out_pre_reg))
        else $error("core both retired and preempted");

    a_full_admit_drops: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.do_admit && full) |=> (count_reg == $past(count_reg)) && out_full_reg)
        else $error("admit into full queue changed the count");

    a_pre_full_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.do_pop && pre_full_reg) |-> dis_reg)
        else $error("preemption into full queue without dispatch");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/multicore_rr_fcfs_scheduler.sv -----
`default_nettype none
// multicore_rr_fcfs_scheduler: top level, configuration registers and wiring
// depends on msched_pkg, msched_ctrl and msched_dp
//
// multicore scheduler with one fifo ready queue of process ids. an admit
// request appends process_id to the queue tail and returns one result; when
// the queue already holds QUEUE_DEPTH ids the id is dropped and queue_full is
// set. a tick request visits cores 0 to NUM_CORES-1 in order and returns one
// result per core, last marking the final one. a busy core whose
// finished_mask bit is set retires its process; otherwise in round robin mode
// a process whose quantum counter reached quantum_limit is preempted to the
// queue tail, else the counter counts up and saturates. a core left free then
// takes the queue head and its counter clears. first come first served mode
// counts but never preempts. timing: an admit passes through accept, queue
// write and result, the result being offered from the wait state after the
// queue write; a tick steps through each core in turn. the steps of a core
// visit are set by the single ported queue memory: evaluate, write the
// preempted id, read the head with a registered read, dispatch and load the
// result register, then hand the result over. one request is worked at a
// time; the next is accepted once the last result is taken, and a stalling
// consumer holds the block until it takes each result.
// registers over apb: policy at 0x0 (0 fcfs, 1 round robin, reset 0) and
// quantum_limit at 0x4 (16 bits, reset 5); write them only while idle.
// queue memory and core process ids need no reset or clearing pass.

module multicore_rr_fcfs_scheduler
    import msched_pkg::*;
#(
    parameter int NUM_CORES   = 4,
    parameter int QUEUE_DEPTH = 16
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // configuration port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [2:0]            paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    // request channel
    input  wire logic                  req_valid,
    output logic                       req_ready,
    input  wire logic                  command,
    input  wire logic [ID_W-1:0]       process_id,
    input  wire logic [MASK_W-1:0]     finished_mask,
    // result channel
    output logic                       rsp_valid,
    input  wire logic                  rsp_ready,
    output logic [CORE_IDX_W-1:0]      core_index,
    output logic                       retired_valid,
    output logic [ID_W-1:0]            retired_id,
    output logic                       preempted_valid,
    output logic [ID_W-1:0]            preempted_id,
    output logic                       dispatched_valid,
    output logic [ID_W-1:0]            dispatched_id,
    output logic                       queue_full,
    output logic                       last
);

    logic              policy_reg;
    logic [QCNT_W-1:0] qlimit_reg;
    logic              cfg_wr;
    logic              reg_sel;

    msched_cmd_t  cmd;
    msched_stat_t stat;

    // register select ignores the byte offset bits
    assign reg_sel = paddr[2];
    assign cfg_wr  = psel & penable & pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= POLICY_FCFS;
            qlimit_reg <= QLIMIT_RESET;
        end
        else if (cfg_wr)
        begin
            case (reg_sel)
                REG_POLICY: policy_reg <= pwdata[0];
                REG_QLIMIT: qlimit_reg <= pwdata[QCNT_W-1:0];
                default:    ;
            endcase
        end
    end

    // read back, low byte offset bits are don't care
    always_comb
    begin
        case (reg_sel)
            REG_POLICY: prdata = {31'b0, policy_reg};
            REG_QLIMIT: prdata = {16'b0, qlimit_reg};
            default:    prdata = '0;
        endcase
        if (paddr[1:0] != 2'b00)
        begin
            prdata = prdata;
        end
    end

    // sequencer: one state per step of a core visit
    msched_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .command   (command),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // queue, core table and result register
    msched_dp #(
        .NUM_CORES   (NUM_CORES),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .policy           (policy_reg),
        .quantum_limit    (qlimit_reg),
        .process_id       (process_id),
        .finished_mask    (finished_mask),
        .core_index       (core_index),
        .retired_valid    (retired_valid),
        .retired_id       (retired_id),
        .preempted_valid  (preempted_valid),
        .preempted_id     (preempted_id),
        .dispatched_valid (dispatched_valid),
        .dispatched_id    (dispatched_id),
        .queue_full       (queue_full),
        .last             (last)
    );

endmodule

`default_nettype wire

// ----- verif/tb_multicore_rr_fcfs_scheduler.sv -----
`timescale 1ns / 100ps
// tb_multicore_rr_fcfs_scheduler: self-checking testbench of the multicore scheduler
// depends on msched_pkg and multicore_rr_fcfs_scheduler; a shadow of the queue and cores
// predicts every result, which is compared field by field as it leaves the block

module tb_multicore_rr_fcfs_scheduler;
    import msched_pkg::*;

    localparam int NUM_CORES     = 4;
    localparam int QUEUE_DEPTH   = 16;
    localparam int IDLE_PCT      = 21;      // chance in a hundred of an idle cycle per side
    localparam int SETTLE_CYCLES = 30;
    localparam int STALL_LIMIT   = 4000;    // cycles with nothing accepted before giving up
    localparam int PHASE_ITEMS   = 72;

    // register byte addresses, index taken from paddr[2]
    localparam logic [2:0] ADDR_POLICY = {REG_POLICY, 2'b00};
    localparam logic [2:0] ADDR_QLIMIT = {REG_QLIMIT, 2'b00};

    // one result as it leaves the block
    typedef struct packed {
        logic [CORE_IDX_W-1:0] core_index;
        logic                  retired_valid;
        logic [ID_W-1:0]       retired_id;
        logic                  preempted_valid;
        logic [ID_W-1:0]       preempted_id;
        logic                  dispatched_valid;
        logic [ID_W-1:0]       dispatched_id;
        logic                  queue_full;
        logic                  last;
    } sched_result_t;

    // shadow copy of the ready queue, the cores and the registers; each accepted
    // request is played against it and the results it causes are queued up
    class sched_shadow;
        sched_result_t     awaited_results[$];
        logic [ID_W-1:0]   ready_ring[QUEUE_DEPTH];
        int                ring_head;
        int                ring_count;
        bit                core_busy[NUM_CORES];
        logic [ID_W-1:0]   core_pid[NUM_CORES];
        logic [QCNT_W-1:0] slice_count[NUM_CORES];
        logic              policy;
        logic [QCNT_W-1:0] quantum_limit;
        int unsigned       errors;
        int unsigned       checked;
        int unsigned       admits;
        int unsigned       ticks;
        int unsigned       dropped;
        int unsigned       retires;
        int unsigned       preempts;
        int unsigned       dispatches;

        function new();
            ring_head     = 0;
            ring_count    = 0;
            policy        = POLICY_FCFS;
            quantum_limit = QLIMIT_RESET;
            foreach (core_busy[c])
            begin
                core_busy[c]   = 1'b0;
                core_pid[c]    = '0;
                slice_count[c] = '0;
            end
        endfunction

        function void ring_push(logic [ID_W-1:0] pid);
            ready_ring[(ring_head + ring_count) % QUEUE_DEPTH] = pid;
            ring_count++;
        endfunction

        function logic [ID_W-1:0] ring_pop();
            logic [ID_W-1:0] pid;
            pid        = ready_ring[ring_head];
            ring_head  = (ring_head + 1) % QUEUE_DEPTH;
            ring_count--;
            return pid;
        endfunction

        function void note_request(logic cmd, logic [ID_W-1:0] pid, logic [MASK_W-1:0] mask);
            sched_result_t r;
            int c;
            if (cmd == CMD_ADMIT)
            begin
                r = '0;
                r.queue_full = (ring_count >= QUEUE_DEPTH);
                r.last = 1'b1;
                if (!r.queue_full)
                    ring_push(pid);
                else
                    dropped++;
                admits++;
                awaited_results.push_back(r);
                return;
            end
            ticks++;
            // mask bits at or above NUM_CORES have no core and fall out here
            for (c = 0; c < NUM_CORES; c++)
            begin
                r = '0;
                r.core_index = CORE_IDX_W'(c);
                if (core_busy[c])
                begin
                    if (mask[c])
                    begin
                        r.retired_valid = 1'b1;
                        r.retired_id    = core_pid[c];
                        core_busy[c]    = 1'b0;
                        slice_count[c]  = '0;
                    end
                    else if (policy == POLICY_RR && slice_count[c] >= quantum_limit)
                    begin
                        r.preempted_valid = 1'b1;
                        r.preempted_id    = core_pid[c];
                        core_busy[c]      = 1'b0;
                        slice_count[c]    = '0;
                    end
                    else if (slice_count[c] != QCNT_MAX)
                        slice_count[c]++;
                end
                // a full queue hands out its head before the preempted id goes in
                if (r.preempted_valid && ring_count >= QUEUE_DEPTH)
                begin
                    r.dispatched_valid = 1'b1;
                    r.dispatched_id    = ring_pop();
                    ring_push(r.preempted_id);
                end
                else
                begin
                    if (r.preempted_valid)
                        ring_push(r.preempted_id);
                    if (!core_busy[c] && ring_count > 0)
                    begin
                        r.dispatched_valid = 1'b1;
                        r.dispatched_id    = ring_pop();
                    end
                end
                if (r.dispatched_valid)
                begin
                    core_busy[c]   = 1'b1;
                    core_pid[c]    = r.dispatched_id;
                    slice_count[c] = '0;
                    dispatches++;
                end
                if (r.retired_valid)
                    retires++;
                if (r.preempted_valid)
                    preempts++;
                r.last = (c == NUM_CORES - 1);
                awaited_results.push_back(r);
            end
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(sched_result_t got);
            sched_result_t want;
            if (awaited_results.size() == 0)
            begin
                $error("result with none awaited: core_index %0d", got.core_index);
                errors++;
                return;
            end
            want = awaited_results.pop_front();
            checked++;
            check_field("core_index", want.core_index, got.core_index);
            check_field("retired_valid", want.retired_valid, got.retired_valid);
            check_field("retired_id", want.retired_id, got.retired_id);
            check_field("preempted_valid", want.preempted_valid, got.preempted_valid);
            check_field("preempted_id", want.preempted_id, got.preempted_id);
            check_field("dispatched_valid", want.dispatched_valid, got.dispatched_valid);
            check_field("dispatched_id", want.dispatched_id, got.dispatched_id);
            check_field("queue_full", want.queue_full, got.queue_full);
            check_field("last", want.last, got.last);
        endfunction
    endclass

    // every input of the block starts at a known value
    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  psel          = 1'b0;
    logic                  penable       = 1'b0;
    logic                  pwrite        = 1'b0;
    logic [2:0]            paddr         = '0;
    logic [31:0]           pwdata        = '0;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  req_valid     = 1'b0;
    logic                  req_ready;
    logic                  command       = CMD_ADMIT;
    logic [ID_W-1:0]       process_id    = '0;
    logic [MASK_W-1:0]     finished_mask = '0;
    logic                  rsp_valid;
    logic                  rsp_ready     = 1'b0;
    logic [CORE_IDX_W-1:0] core_index;
    logic                  retired_valid;
    logic [ID_W-1:0]       retired_id;
    logic                  preempted_valid;
    logic [ID_W-1:0]       preempted_id;
    logic                  dispatched_valid;
    logic [ID_W-1:0]       dispatched_id;
    logic                  queue_full;
    logic                  last;

    sched_shadow shadow_sched;
    bit          pace_on = 1'b1;    // random idling on both sides
    int unsigned requests_sent = 0;

    multicore_rr_fcfs_scheduler dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .req_valid        (req_valid),
        .req_ready        (req_ready),
        .command          (command),
        .process_id       (process_id),
        .finished_mask    (finished_mask),
        .rsp_valid        (rsp_valid),
        .rsp_ready        (rsp_ready),
        .core_index       (core_index),
        .retired_valid    (retired_valid),
        .retired_id       (retired_id),
        .preempted_valid  (preempted_valid),
        .preempted_id     (preempted_id),
        .dispatched_valid (dispatched_valid),
        .dispatched_id    (dispatched_id),
        .queue_full       (queue_full),
        .last             (last)
    );

    always #6 clk = ~clk;

    // result side: check what left at this edge, then pick the next ready value
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            shadow_sched.check_result({core_index, retired_valid, retired_id,
                                       preempted_valid, preempted_id, dispatched_valid,
                                       dispatched_id, queue_full, last});
        rsp_ready <= pace_on ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
    end

    // watchdog: ends the run once nothing has moved for too long
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable))
                quiet = 0;
            else
                quiet++;
        end
        $display("** multicore_rr_fcfs_scheduler: FAILED **");
        $finish;
    end

    // present one request and hold it until accepted; the shadow plays it at acceptance
    task automatic send_request(logic cmd, logic [ID_W-1:0] pid, logic [MASK_W-1:0] mask);
        while (pace_on && $urandom_range(99) < IDLE_PCT)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid     <= 1'b1;
        command       <= cmd;
        process_id    <= pid;
        finished_mask <= mask;
        do
            @(posedge clk);
        while (!req_ready);
        shadow_sched.note_request(cmd, pid, mask);
        requests_sent++;
    endtask

    // drop valid, let every awaited result come out, then give the block time to go idle
    task automatic wait_drained();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (shadow_sched.awaited_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // apb write: setup cycle, then access until pready
    task automatic write_reg(logic [2:0] addr, logic [31:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic read_reg(logic [2:0] addr, output logic [31:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        data     = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // registers change only with the block idle; both are read back
    task automatic set_config(logic pol, logic [QCNT_W-1:0] lim);
        logic [31:0] rd;
        wait_drained();
        write_reg(ADDR_POLICY, {31'd0, pol});
        shadow_sched.policy = pol;
        write_reg(ADDR_QLIMIT, {16'd0, lim});
        shadow_sched.quantum_limit = lim;
        read_reg(ADDR_POLICY, rd);
        shadow_sched.check_field("policy readback", pol, rd[0]);
        read_reg(ADDR_QLIMIT, rd);
        shadow_sched.check_field("quantum_limit readback", lim, rd[QCNT_W-1:0]);
    endtask

    // mostly admit/tick traffic that keeps the queue moving, with rare admit bursts
    // to drive it into the full state
    task automatic random_request();
        int unsigned pick;
        int unsigned burst;
        logic [MASK_W-1:0] mask;
        pick = $urandom_range(99);
        if (pick < 3)
        begin
            burst = $urandom_range(18, 8);
            repeat (burst) send_request(CMD_ADMIT, ID_W'($urandom), MASK_W'($urandom));
        end
        else if (pick < 48)
            send_request(CMD_ADMIT, ID_W'($urandom), MASK_W'($urandom));
        else
        begin
            pick = $urandom_range(99);
            if (pick < 20)
                mask = '0;
            else if (pick < 90)
                mask = MASK_W'($urandom & $urandom);   // sparse: few processes finish
            else
                mask = MASK_W'($urandom);
            send_request(CMD_TICK, ID_W'($urandom), mask);
        end
    endtask

    task automatic run_phase(logic pol, logic [QCNT_W-1:0] lim, bit paced, bit hold_midway);
        int unsigned phase_end;
        bit held;
        held = 1'b0;
        set_config(pol, lim);
        pace_on   <= paced;
        phase_end = requests_sent + PHASE_ITEMS;
        while (requests_sent < phase_end)
        begin
            // sender holds off until the block has handed back everything it owes
            if (hold_midway && !held && requests_sent >= phase_end - PHASE_ITEMS / 2)
            begin
                wait_drained();
                held = 1'b1;
            end
            random_request();
        end
    endtask

    initial
    begin : stimulus
        int k;
        shadow_sched = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed part, default registers (first come first served, limit 5)
        // finished bits on idle cores do nothing
        send_request(CMD_TICK, 8'h00, 8'hFF);
        // fill the queue with ids from 0 upward; the last admit, id 255, finds it full
        for (k = 0; k <= QUEUE_DEPTH; k++)
            send_request(CMD_ADMIT, ID_W'(k * 255 / QUEUE_DEPTH), 8'h00);
        // only mask bits above the cores set: all four cores dispatch
        send_request(CMD_TICK, 8'hFF, 8'hF0);
        send_request(CMD_ADMIT, 8'hAA, 8'h00);
        send_request(CMD_ADMIT, 8'h55, 8'hFF);
        send_request(CMD_ADMIT, 8'h01, 8'h00);
        send_request(CMD_ADMIT, 8'h80, 8'h00);

        // round robin with a zero limit: every core is preempted into a full queue
        set_config(POLICY_RR, 16'd0);
        send_request(CMD_TICK, 8'h00, 8'h00);
        // retire and refill until the queue runs dry
        repeat (4) send_request(CMD_TICK, 8'h00, 8'h0F);
        // preemption with nothing waiting: each process comes straight back
        send_request(CMD_TICK, 8'h00, 8'h00);
        send_request(CMD_TICK, 8'h00, 8'hFF);

        // random part across several register settings, extremes among them
        run_phase(POLICY_RR,   16'd2,                        1'b1, 1'b0);
        run_phase(POLICY_FCFS, 16'd0,                        1'b1, 1'b0);
        run_phase(POLICY_RR,   16'hFFFF,                     1'b1, 1'b0);
        run_phase(POLICY_RR,   16'd0,                        1'b0, 1'b0);
        run_phase(POLICY_RR,   QCNT_W'($urandom_range(6)),   1'b1, 1'b1);
        run_phase(POLICY_RR,   16'd1,                        1'b1, 1'b0);

        wait_drained();
        $display("run covered %0d requests: %0d admits (%0d dropped on a full queue), %0d ticks",
                 requests_sent, shadow_sched.admits, shadow_sched.dropped, shadow_sched.ticks);
        $display("checked %0d results: %0d retirements, %0d preemptions, %0d dispatches",
                 shadow_sched.checked, shadow_sched.retires, shadow_sched.preempts,
                 shadow_sched.dispatches);
        if (shadow_sched.errors == 0 && shadow_sched.awaited_results.size() == 0)
            $display("** multicore_rr_fcfs_scheduler: PASSED **");
        else
            $display("** multicore_rr_fcfs_scheduler: FAILED **");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/msched_pkg.sv
hw/rtl/msched_ctrl.sv
hw/rtl/msched_dp.sv
hw/rtl/multicore_rr_fcfs_scheduler.sv
verif/tb_multicore_rr_fcfs_scheduler.sv
